// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/ffbt_pkg.sv =====
// Package for the first-fit boundary-tag heap: request and response types, codes and constants.
package ffbt_pkg;

	localparam int HEAP_BYTES_DEF = 65536;
	localparam int TAG_BYTES      = 8;
	localparam int OVERHEAD       = 16;
	localparam int ROUND_STEP     = 40;
	localparam int PATTERN_LEN    = 5;
	localparam int DIV5_MUL       = 52429;
	localparam int DIV5_SHIFT     = 18;
	localparam logic [16:0] ARENA_LEN_RST = 17'd65536;

	localparam logic [2:0] CMD_FORMAT = 3'd0;
	localparam logic [2:0] CMD_ALLOC  = 3'd1;
	localparam logic [2:0] CMD_FREE   = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_WRITE  = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FIT    = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
	localparam logic [1:0] ST_BOUNDS    = 2'd3;

	localparam logic CFG_ARENA_LEN = 1'b0;
	localparam logic CFG_FILL      = 1'b1;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] request_size;
		logic [15:0] handle;
		logic [15:0] byte_offset;
		logic [3:0]  access_length;
		logic [63:0] write_data;
	} cmd_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] new_handle;
		logic [63:0] read_data;
	} cmd_rsp_t;

endpackage

// ===== design/ffbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/first_fit_boundary_tag_heap.sv =====
// Top level of the first-fit boundary-tag heap allocator.
// All work goes through one byte-wide RAM, with one write port and one read
// port, at most one byte per cycle, under a small sequencer; busy is high from
// an accepted command until its result. Format writes the first header. Read
// and write move their bytes only when not refused, and take longer by length.
// Allocate walks the headers, rounds each candidate, then writes header, footer
// and remainder tag. Free refills its bytes, walks the headers from offset 0
// to find the left neighbour, and merges. After reset a clearing pass zeroes
// all HEAP_BYTES bytes of the store with busy high; config writes are taken
// meanwhile. Each result shows for one cycle with done high and cannot be
// held off.
module first_fit_boundary_tag_heap #(
	parameter int HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ffbt_pkg::cmd_req_t req,
	output logic              done,
	output ffbt_pkg::cmd_rsp_t rsp,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [39:0]       cfg_data
);
	import ffbt_pkg::*;

	localparam int LW = $clog2(HEAP_BYTES);
	localparam int AW = ((LW > 16) ? LW : 16) + 2;
	localparam int MW = AW + 13;
	localparam logic [AW-1:0] HEAP_A = AW'(HEAP_BYTES);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RD, S_WR, S_FILL, S_DIV, S_OK, S_DONE,
		S_A_LOOP, S_A_CHK, S_A_TST, S_A_EDGE, S_A_FTR, S_A_REST,
		S_F_CHK, S_F_FILL, S_F_BB, S_BB_LOOP, S_BB_CHK, S_BB_END,
		S_F_MP, S_F_NX, S_F_NX2, S_F_NX3, S_F_NX4,
		S_ACC_CHK, S_ACC_RD
	} state_t;

	state_t      st_q, ret_q;
	cmd_req_t    req_q;
	cmd_rsp_t    rsp_q;
	logic        done_q;
	logic [16:0] arena_len_q;
	logic [39:0] pat_q;
	logic [LW-1:0] clr_q;

	logic [AW-1:0] base_q;
	logic [3:0]    len_q, idx_q;
	logic [63:0]   tag_q, wdat_q;
	logic          rvld_s1, rin_s1;
	logic [2:0]    ridx_s1;

	logic [AW-1:0] fa_q;
	logic [63:0]   fcnt_q;
	logic [2:0]    fph_q;

	logic [63:0]   cur_q, bs_q, sz_q, prevsz_q, prevraw_q;
	logic [AW-1:0] prev_q, blk_q, nxt_q, xs_q, edge_q;
	logic          have_q;

	logic [1:0]  stat_q;
	logic [15:0] nh_q;
	logic [63:0] rd_q;

	logic [AW-1:0] hs, io_addr, edge_n, dist_v;
	logic [63:0]   hs64, bs_t, nxt_t, room_v;
	logic [64:0]   cur_adv;
	logic [MW-1:0] qmul_v;
	logic          io_in;
	logic          ram_we;
	logic [LW-1:0] ram_waddr;
	logic [7:0]    ram_wdata, ram_rdata;

	assign hs      = (AW'(arena_len_q) < HEAP_A) ? AW'(arena_len_q) : HEAP_A;
	assign hs64    = 64'(hs);
	assign io_addr = base_q + AW'(idx_q);
	assign io_in   = io_addr < HEAP_A;
	assign bs_t    = {tag_q[63:1], 1'b0};
	assign nxt_t   = 64'(blk_q) + bs_t;
	assign cur_adv = {1'b0, cur_q} + {1'b0, bs_q};
	// x / 40 as (x / 8) / 5 by reciprocal multiply, then back up by 32 + 8
	assign qmul_v  = MW'(xs_q[AW-1:3]) * MW'(DIV5_MUL);
	assign edge_n  = AW'({qmul_v[MW-1:DIV5_SHIFT], 5'b00000})
		+ AW'({qmul_v[MW-1:DIV5_SHIFT], 3'b000});
	assign dist_v  = edge_q - cur_q[AW-1:0];
	assign room_v  = (bs_t >= 64'(OVERHEAD)) ? bs_t - 64'(OVERHEAD) : 64'd0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = io_addr[LW-1:0];
		ram_wdata = wdat_q[{idx_q[2:0], 3'b000} +: 8];
		case (st_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 8'd0;
			end
			S_WR: begin
				ram_we = (idx_q < len_q) && io_in;
			end
			S_FILL: begin
				ram_we    = (fcnt_q != 64'd0) && (fa_q < hs);
				ram_waddr = fa_q[LW-1:0];
				ram_wdata = 8'(pat_q >> {fph_q, 3'b000});
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ffbt_ram #(.WIDTH(8), .DEPTH(HEAP_BYTES)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(io_addr[LW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_len_q <= ARENA_LEN_RST;
			pat_q       <= 40'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ARENA_LEN: arena_len_q <= cfg_data[16:0];
				CFG_FILL:      pat_q       <= cfg_data;
				default:       arena_len_q <= arena_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_CLR;
			ret_q   <= S_IDLE;
			clr_q   <= '0;
			done_q  <= 1'b0;
			rvld_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LW'(HEAP_BYTES - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q  <= req;
						stat_q <= ST_NO_FIT;
						nh_q   <= 16'd0;
						rd_q   <= 64'd0;
						case (req.cmd)
							CMD_FORMAT: begin
								if (arena_len_q == 17'd0) begin
									st_q <= S_DONE;
								end else begin
									base_q <= '0;
									len_q  <= 4'd8;
									idx_q  <= 4'd0;
									wdat_q <= {hs64[63:1], 1'b0};
									ret_q  <= S_OK;
									st_q   <= S_WR;
								end
							end
							CMD_ALLOC: begin
								cur_q <= 64'd0;
								st_q  <= (req.request_size == 16'd0) ? S_DONE : S_A_LOOP;
							end
							CMD_FREE, CMD_READ, CMD_WRITE: begin
								base_q <= AW'(req.handle);
								len_q  <= 4'd8;
								idx_q  <= 4'd0;
								tag_q  <= 64'd0;
								ret_q  <= (req.cmd == CMD_FREE) ? S_F_CHK : S_ACC_CHK;
								st_q   <= S_RD;
							end
							default: begin
								st_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD: begin
					if (rvld_s1 && rin_s1) begin
						tag_q[{ridx_s1, 3'b000} +: 8] <= ram_rdata;
					end
					if (idx_q < len_q) begin
						rvld_s1 <= 1'b1;
						ridx_s1 <= idx_q[2:0];
						rin_s1  <= io_in;
						idx_q   <= idx_q + 4'd1;
					end else begin
						rvld_s1 <= 1'b0;
						if (!rvld_s1) begin
							st_q <= ret_q;
						end
					end
				end
				S_WR: begin
					if (idx_q < len_q) begin
						idx_q <= idx_q + 4'd1;
					end else begin
						st_q <= ret_q;
					end
				end
				S_FILL: begin
					if ((fcnt_q == 64'd0) || (fa_q >= hs)) begin
						st_q <= ret_q;
					end else begin
						fa_q   <= fa_q + 1'b1;
						fcnt_q <= fcnt_q - 64'd1;
						fph_q  <= (fph_q == 3'(PATTERN_LEN - 1)) ? 3'd0 : fph_q + 3'd1;
					end
				end
				S_OK: begin
					stat_q <= ST_OK;
					st_q   <= S_DONE;
				end
				S_DONE: begin
					rsp_q  <= '{status: stat_q, new_handle: nh_q, read_data: rd_q};
					done_q <= 1'b1;
					st_q   <= S_IDLE;
				end
				// allocate
				S_A_LOOP: begin
					if (cur_q >= hs64) begin
						st_q <= S_DONE;
					end else begin
						base_q <= cur_q[AW-1:0];
						len_q  <= 4'd8;
						idx_q  <= 4'd0;
						tag_q  <= 64'd0;
						ret_q  <= S_A_CHK;
						st_q   <= S_RD;
					end
				end
				S_A_CHK: begin
					bs_q <= bs_t;
					st_q <= (bs_t == 64'd0) ? S_DONE : S_A_TST;
				end
				S_A_TST: begin
					if (!tag_q[0] && (bs_q >= 64'(OVERHEAD))
							&& ((bs_q - 64'(OVERHEAD)) >= 64'(req_q.request_size))) begin
						xs_q   <= cur_q[AW-1:0] + AW'(OVERHEAD + ROUND_STEP - 1)
							+ AW'(req_q.request_size);
						st_q   <= S_DIV;
					end else if (cur_adv[64] || (cur_adv[63:0] >= hs64)) begin
						st_q <= S_DONE;
					end else begin
						cur_q <= cur_adv[63:0];
						st_q  <= S_A_LOOP;
					end
				end
				S_DIV: begin
					edge_q <= edge_n;
					st_q   <= S_A_EDGE;
				end
				S_A_EDGE: begin
					if (64'(dist_v) <= bs_q) begin
						sz_q   <= bs_q - 64'(dist_v);
						base_q <= cur_q[AW-1:0];
						len_q  <= 4'd8;
						idx_q  <= 4'd0;
						wdat_q <= 64'(dist_v) | 64'd1;
						ret_q  <= S_A_FTR;
						st_q   <= S_WR;
					end else if (cur_adv[64] || (cur_adv[63:0] >= hs64)) begin
						st_q <= S_DONE;
					end else begin
						cur_q <= cur_adv[63:0];
						st_q  <= S_A_LOOP;
					end
				end
				S_A_FTR: begin
					base_q <= edge_q - AW'(TAG_BYTES);
					idx_q  <= 4'd0;
					ret_q  <= S_A_REST;
					st_q   <= S_WR;
				end
				S_A_REST: begin
					nh_q   <= cur_q[15:0];
					base_q <= edge_q;
					idx_q  <= 4'd0;
					wdat_q <= (sz_q >= 64'(TAG_BYTES)) ? {sz_q[63:1], 1'b0} : 64'd0;
					ret_q  <= S_OK;
					st_q   <= (sz_q != 64'd0) ? S_WR : S_OK;
				end
				// free
				S_F_CHK: begin
					if (!tag_q[0]) begin
						stat_q <= ST_NOT_ALLOC;
						st_q   <= S_DONE;
					end else begin
						sz_q   <= bs_t;
						idx_q  <= 4'd0;
						wdat_q <= bs_t;
						ret_q  <= S_F_FILL;
						st_q   <= S_WR;
					end
				end
				S_F_FILL: begin
					fa_q   <= AW'(req_q.handle) + AW'(TAG_BYTES);
					fcnt_q <= sz_q - 64'(TAG_BYTES);
					fph_q  <= 3'd0;
					ret_q  <= S_F_BB;
					st_q   <= (sz_q > 64'(TAG_BYTES)) ? S_FILL : S_F_BB;
				end
				S_F_BB: begin
					blk_q  <= AW'(req_q.handle);
					cur_q  <= 64'd0;
					have_q <= 1'b0;
					st_q   <= (req_q.handle == 16'd0) ? S_F_NX : S_BB_LOOP;
				end
				S_BB_LOOP: begin
					if (cur_q < 64'(req_q.handle)) begin
						base_q <= cur_q[AW-1:0];
						len_q  <= 4'd8;
						idx_q  <= 4'd0;
						tag_q  <= 64'd0;
						ret_q  <= S_BB_CHK;
						st_q   <= S_RD;
					end else begin
						st_q <= S_BB_END;
					end
				end
				S_BB_CHK: begin
					if (bs_t == 64'd0) begin
						st_q <= S_BB_END;
					end else begin
						prev_q    <= cur_q[AW-1:0];
						have_q    <= 1'b1;
						prevsz_q  <= bs_t;
						prevraw_q <= tag_q;
						if ((cur_q + bs_t) < cur_q) begin
							st_q <= S_BB_END;
						end else begin
							cur_q <= cur_q + bs_t;
							st_q  <= S_BB_LOOP;
						end
					end
				end
				S_BB_END: begin
					if (have_q && !prevraw_q[0]
							&& ((64'(prev_q) + prevsz_q) == 64'(req_q.handle))) begin
						base_q <= AW'(req_q.handle);
						len_q  <= 4'd8;
						idx_q  <= 4'd0;
						tag_q  <= 64'd0;
						ret_q  <= S_F_MP;
						st_q   <= S_RD;
					end else begin
						st_q <= S_F_NX;
					end
				end
				S_F_MP: begin
					blk_q  <= prev_q;
					base_q <= prev_q;
					idx_q  <= 4'd0;
					wdat_q <= prevraw_q + tag_q;
					ret_q  <= S_F_NX;
					st_q   <= S_WR;
				end
				S_F_NX: begin
					base_q <= blk_q;
					len_q  <= 4'd8;
					idx_q  <= 4'd0;
					tag_q  <= 64'd0;
					ret_q  <= S_F_NX2;
					st_q   <= S_RD;
				end
				S_F_NX2: begin
					sz_q <= tag_q;
					if (nxt_t < hs64) begin
						nxt_q  <= nxt_t[AW-1:0];
						base_q <= nxt_t[AW-1:0];
						idx_q  <= 4'd0;
						tag_q  <= 64'd0;
						ret_q  <= S_F_NX3;
						st_q   <= S_RD;
					end else begin
						st_q <= S_OK;
					end
				end
				S_F_NX3: begin
					if (!tag_q[0]) begin
						bs_q   <= bs_t;
						base_q <= blk_q;
						idx_q  <= 4'd0;
						wdat_q <= sz_q + tag_q;
						ret_q  <= S_F_NX4;
						st_q   <= S_WR;
					end else begin
						st_q <= S_OK;
					end
				end
				S_F_NX4: begin
					fa_q   <= nxt_q;
					fcnt_q <= bs_q;
					fph_q  <= 3'd0;
					ret_q  <= S_OK;
					st_q   <= S_FILL;
				end
				// checked read and write
				S_ACC_CHK: begin
					if (!tag_q[0]) begin
						stat_q <= ST_NOT_ALLOC;
						st_q   <= S_DONE;
					end else if ((req_q.access_length > 4'd8)
							|| ((64'(req_q.byte_offset) + 64'(req_q.access_length)) > room_v)) begin
						stat_q <= ST_BOUNDS;
						st_q   <= S_DONE;
					end else begin
						base_q <= AW'(req_q.handle) + AW'(TAG_BYTES) + AW'(req_q.byte_offset);
						len_q  <= req_q.access_length;
						idx_q  <= 4'd0;
						tag_q  <= 64'd0;
						wdat_q <= req_q.write_data;
						ret_q  <= (req_q.cmd == CMD_READ) ? S_ACC_RD : S_OK;
						st_q   <= (req_q.cmd == CMD_READ) ? S_RD : S_WR;
					end
				end
				S_ACC_RD: begin
					rd_q <= tag_q;
					st_q <= S_OK;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule

// ===== design/ffbt_checker.sv =====
// Port-level checker for the heap allocator, bound to the top level.
module ffbt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input ffbt_pkg::cmd_rsp_t rsp
);
	import ffbt_pkg::*;
	`include "assert_macros.svh"

	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
	`ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")
	`ASSERT_SAME(a_fail_zero, done && (rsp.status != ST_OK),
		(rsp.new_handle == 16'd0) && (rsp.read_data == 64'd0),
		"failed command returns nonzero data")
endmodule

bind first_fit_boundary_tag_heap ffbt_checker u_ffbt_checker (.*);
